// ===== hw/rtl/bounded_ordered_list_engine_macros.svh =====
// Assertion macros shared by the bounded ordered list engine RTL.
// Depends on nothing; included by bounded_ordered_list_engine, which carries assertions.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BOLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BOLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bole_pkg.sv =====
// Shared constants and types for the bounded ordered list engine.
// Depends on nothing; used by bole_cell and bounded_ordered_list_engine.
package bole_pkg;

    // Number of storage cells and the width of the element count.
    localparam int DEPTH   = 64;
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int VAL_W   = 32;
    localparam int MODE_W  = 3;

    // Operation codes carried by the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_INS_HEAD = 3'd0,
        MODE_INS_TAIL = 3'd1,
        MODE_INS_SORT = 3'd2,
        MODE_REM_HEAD = 3'd3,
        MODE_REM_TAIL = 3'd4,
        MODE_REM_VAL  = 3'd5,
        MODE_CONTAINS = 3'd6
    } t_mode;

    // Sequencer states: idle, compare in every cell, apply the shift.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY
    } t_state;

    // Per-cell load control for the apply cycle.
    typedef struct packed {
        logic load_value;
        logic from_left;
        logic from_right;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/bole_cell.sv =====
// One storage cell of the list: holds a slot, compares it against the
// operand and loads from the operand or a neighbor. Depends on bole_pkg.
module bole_cell
    import bole_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_cmp_en,
    input  logic signed [VAL_W-1:0] i_value,
    input  t_cell_ctl               i_ctl,
    input  logic signed [VAL_W-1:0] i_left,
    input  logic signed [VAL_W-1:0] i_right,
    output logic signed [VAL_W-1:0] o_slot,
    output logic                    o_eq,
    output logic                    o_ge,
    output logic                    o_gt
);

    logic signed [VAL_W-1:0] r_slot;
    logic                    r_eq;
    logic                    r_ge;
    logic                    r_gt;

    // Capture the comparison flags against the operand.
    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_eq <= (r_slot == i_value);
            r_ge <= (r_slot >= i_value);
            r_gt <= (r_slot > i_value);
        end
    end

    // Slot update: operand first, then a shift from either neighbor.
    // With no load requested the slot keeps its value.
    always_ff @(posedge i_clk) begin
        priority if (i_ctl.load_value) begin
            r_slot <= i_value;
        end else if (i_ctl.from_left) begin
            r_slot <= i_left;
        end else if (i_ctl.from_right) begin
            r_slot <= i_right;
        end else begin
            r_slot <= r_slot;
        end
    end

    assign o_slot = r_slot;
    assign o_eq   = r_eq;
    assign o_ge   = r_ge;
    assign o_gt   = r_gt;

endmodule

// ===== hw/rtl/bounded_ordered_list_engine.sv =====
// Bounded ordered list engine: keeps up to DEPTH (64) signed 32-bit values in a
// row of cells, head in cell 0, and runs one list operation per transaction.
// Each transaction runs from acceptance to a loaded result: the operation is
// registered, every cell compares its value with the operand, and the insert or
// remove position is found from the cell flags and all cells shift at once, held
// while an earlier result stalls. The input stalls while a transaction is in
// flight; the result register lets the next transaction start while the previous
// result waits to be taken. No clearing pass is needed after reset.
`include "bounded_ordered_list_engine_macros.svh"

module bounded_ordered_list_engine
    import bole_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_ok,
    output logic signed [VAL_W-1:0] o_removed_value,
    output logic [FILL_W-1:0]       o_count
);

    t_state                  r_state;
    t_state                  n_state;
    logic [MODE_W-1:0]       r_mode;
    logic signed [VAL_W-1:0] r_value;
    logic [FILL_W-1:0]       r_fill;
    logic [FILL_W-1:0]       n_fill;
    logic                    r_out_valid;
    logic                    r_ok;
    logic                    n_ok;
    logic signed [VAL_W-1:0] r_rem;
    logic signed [VAL_W-1:0] n_rem;

    logic                    w_in_acc;
    logic                    w_out_acc;
    logic                    w_cmp_en;
    logic                    w_apply_en;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_is_ins;
    logic                    w_ins_go;
    logic                    w_shift_rem;
    logic                    w_found;

    logic [DEPTH-1:0]        w_valid;
    logic [DEPTH-1:0]        w_last;
    logic [DEPTH-1:0]        w_eq;
    logic [DEPTH-1:0]        w_ge;
    logic [DEPTH-1:0]        w_gt;
    logic [DEPTH-1:0]        w_sel;
    logic [DEPTH-1:0]        w_onehot;
    logic [DEPTH-1:0]        w_tail_mask;
    logic signed [VAL_W-1:0] w_slot [DEPTH];
    logic signed [VAL_W-1:0] w_tail_val;
    t_cell_ctl               w_ctl [DEPTH];

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = r_out_valid && !i_out_stall;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_CMP;
            ST_CMP:   n_state = ST_APPLY;
            ST_APPLY: if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_stall = 1'b1;
        w_cmp_en   = 1'b0;
        w_apply_en = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_in_stall = 1'b0;
            ST_CMP:   w_cmp_en   = 1'b1;
            ST_APPLY: w_apply_en = !r_out_valid || !i_out_stall;
            default:  o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Operation register.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode  <= i_mode;
            r_value <= i_value;
        end
    end

    // Occupancy of each cell and the one-hot position of the tail.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_valid
        assign w_valid[gi] = FILL_W'(gi) < r_fill;
    end
    assign w_last  = w_valid & ~{1'b0, w_valid[DEPTH-1:1]};
    assign w_full  = (r_fill == FILL_W'(DEPTH));
    assign w_empty = (r_fill == '0);

    // Cells whose flag can mark the operation's position.
    always_comb begin
        w_sel = '0;
        unique case (r_mode)
            MODE_INS_HEAD: w_sel = '1;
            MODE_INS_TAIL: w_sel = ~w_valid;
            MODE_INS_SORT: w_sel = ~w_valid | (w_valid & {w_ge[DEPTH-1:1], w_gt[0]});
            MODE_REM_HEAD: w_sel = '1;
            MODE_REM_VAL:  w_sel = w_eq & w_valid;
            default:       w_sel = '0;
        endcase
    end

    // First marked cell, and the mask of that cell and all beyond it.
    assign w_onehot    = w_sel & (~w_sel + DEPTH'(1));
    assign w_tail_mask = ~(w_onehot - DEPTH'(1));

    assign w_is_ins    = (r_mode == MODE_INS_HEAD) || (r_mode == MODE_INS_TAIL)
                      || (r_mode == MODE_INS_SORT);
    assign w_found     = |(w_eq & w_valid);
    assign w_ins_go    = w_is_ins && !w_full;
    assign w_shift_rem = ((r_mode == MODE_REM_HEAD) && !w_empty)
                      || ((r_mode == MODE_REM_VAL) && w_found);

    // Per-cell control for the apply cycle.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_ctl
        if (gi == 0) begin : g_head
            assign w_ctl[gi].load_value = w_apply_en && w_ins_go && w_tail_mask[gi];
            assign w_ctl[gi].from_left  = 1'b0;
        end else begin : g_body
            assign w_ctl[gi].load_value = w_apply_en && w_ins_go && w_tail_mask[gi]
                                       && !w_tail_mask[gi-1];
            assign w_ctl[gi].from_left  = w_apply_en && w_ins_go && w_tail_mask[gi-1];
        end
        assign w_ctl[gi].from_right = w_apply_en && w_shift_rem && w_tail_mask[gi];
    end

    // The row of cells, each wired to its neighbors.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        bole_cell u_cell (
            .i_clk    (i_clk),
            .i_cmp_en (w_cmp_en),
            .i_value  (r_value),
            .i_ctl    (w_ctl[gi]),
            .i_left   (w_slot[(gi == 0) ? 0 : gi - 1]),
            .i_right  (w_slot[(gi == DEPTH - 1) ? gi : gi + 1]),
            .o_slot   (w_slot[gi]),
            .o_eq     (w_eq[gi]),
            .o_ge     (w_ge[gi]),
            .o_gt     (w_gt[gi])
        );
    end

    // Tail value, gathered by AND-OR over the cells.
    always_comb begin
        w_tail_val = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_tail_val = w_tail_val | (w_slot[k] & {VAL_W{w_last[k]}});
        end
    end

    // Result and new count.
    always_comb begin
        n_ok   = 1'b0;
        n_rem  = '0;
        n_fill = r_fill;
        unique case (r_mode)
            MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_SORT: begin
                n_ok = !w_full;
                if (!w_full) n_fill = r_fill + FILL_W'(1);
            end
            MODE_REM_HEAD: begin
                n_ok = !w_empty;
                if (!w_empty) begin
                    n_rem  = w_slot[0];
                    n_fill = r_fill - FILL_W'(1);
                end
            end
            MODE_REM_TAIL: begin
                n_ok = !w_empty;
                if (!w_empty) begin
                    n_rem  = w_tail_val;
                    n_fill = r_fill - FILL_W'(1);
                end
            end
            MODE_REM_VAL: begin
                n_ok = w_found;
                if (w_found) n_fill = r_fill - FILL_W'(1);
            end
            MODE_CONTAINS: n_ok = w_found;
            default:       n_ok = 1'b0;
        endcase
    end

    // Element count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_apply_en) begin
            r_fill <= n_fill;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_apply_en) begin
            r_out_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply_en) begin
            r_ok  <= n_ok;
            r_rem <= n_rem;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_ok;
    assign o_removed_value = r_rem;
    assign o_count         = r_fill;

    // Checks on the sequencer, count and result register.
    `BOLE_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(DEPTH), "fill above depth")
    `BOLE_ASSERT_NEXT(a_accept_cmp, i_clk, i_rst_n, w_in_acc, r_state == ST_CMP, "accept did not start compare")
    `BOLE_ASSERT_NEXT(a_apply_loads, i_clk, i_rst_n, w_apply_en, r_out_valid && (r_state == ST_IDLE), "apply did not load result")
    `BOLE_ASSERT_NEXT(a_full_insert, i_clk, i_rst_n, w_apply_en && w_is_ins && w_full, !r_ok && (r_fill == $past(r_fill)), "insert into full list changed it")

endmodule
